>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rbaw_pkg.sv
package rbaw_pkg;

  // Widest pointer the design supports; used as a common width for casts.
  localparam int AddrMaxW = 32;
  localparam int DEFAULT_ADDR_BITS = 24;
  localparam int DEFAULT_MAX_DIM = 4096;

  // Fixed field widths of the streams and registers.
  localparam int PixW = 16;
  localparam int FieldAddrW = 24;
  localparam int SkipW = 16;
  localparam int DimRegW = 13;
  localparam int RopW = 4;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_SRC_START    = 3'd0,
    REG_SRC_ROW_SKIP = 3'd1,
    REG_DST_START    = 3'd2,
    REG_DST_ROW_SKIP = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_RASTER_OP    = 3'd6,
    REG_BACKWARD     = 3'd7
  } reg_idx_t;

  // Raster operation codes.
  typedef enum logic [3:0] {
    ROP_CLEAR    = 4'd0,
    ROP_AND      = 4'd1,
    ROP_AND_NDST = 4'd2,
    ROP_COPY     = 4'd3,
    ROP_NSRC_AND = 4'd4,
    ROP_NOP      = 4'd5,
    ROP_XOR      = 4'd6,
    ROP_OR       = 4'd7,
    ROP_NOR      = 4'd8,
    ROP_XNOR     = 4'd9,
    ROP_NDST     = 4'd10,
    ROP_OR_NDST  = 4'd11,
    ROP_NSRC     = 4'd12,
    ROP_NSRC_OR  = 4'd13,
    ROP_NAND     = 4'd14,
    ROP_SET      = 4'd15
  } rop_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [FieldAddrW-1:0] src_start;
    logic [SkipW-1:0]      src_row_skip;
    logic [FieldAddrW-1:0] dst_start;
    logic [SkipW-1:0]      dst_row_skip;
    logic [DimRegW-1:0]    rect_width;
    logic [DimRegW-1:0]    rect_height;
    logic [RopW-1:0]       raster_op;
    logic                  backward;
  } cfg_t;

  // One walked pixel waiting for the combine stage.
  typedef struct packed {
    logic [FieldAddrW-1:0] waddr;
    logic [FieldAddrW-1:0] raddr;
    logic [PixW-1:0]       src;
    logic [PixW-1:0]       dst;
    logic                  last;
  } qent_t;

  // Walker status seen at the top level.
  typedef struct packed {
    logic at_start;
  } front_stat_t;

  // Boolean combine of source and destination pixels.
  function automatic logic [PixW-1:0] rop_combine(input logic [RopW-1:0] op,
                                                  input logic [PixW-1:0] s,
                                                  input logic [PixW-1:0] d);
    logic [PixW-1:0] v;
    unique case (rop_t'(op))
      ROP_CLEAR:    v = '0;
      ROP_AND:      v = s & d;
      ROP_AND_NDST: v = s & ~d;
      ROP_COPY:     v = s;
      ROP_NSRC_AND: v = ~s & d;
      ROP_NOP:      v = d;
      ROP_XOR:      v = s ^ d;
      ROP_OR:       v = s | d;
      ROP_NOR:      v = ~(s | d);
      ROP_XNOR:     v = ~(s ^ d);
      ROP_NDST:     v = ~d;
      ROP_OR_NDST:  v = s | ~d;
      ROP_NSRC:     v = ~s;
      ROP_NSRC_OR:  v = ~s | d;
      ROP_NAND:     v = ~(s & d);
      ROP_SET:      v = '1;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/rop_blit_address_walker_unit.sv
// Channel   Dir  Word contents (low bit up)
// in_       in   tdata: src_pixel[15:0], dst_pixel[31:16]
// out_      out  tdata: write_address[23:0], write_value[39:24], read_address[63:40];
//                tlast: last_pixel
// cfg_      in   APB, 8 registers at byte address 4*index, pready tied high
//
// One word in and one word out per cycle sustained while out_tready stays high; an accepted
// word goes into the queue and is loaded from there, combined, into the output register when
// that register is free or being drained.
// The two-entry queue between walker and combine stage takes up an output stall;
// in_tready drops only once the queue is full.
// Reset (synchronous, active low) clears counters, pointers, queue fill and output valid.
`include "assert_macros.svh"

module rop_blit_address_walker_unit #(
  parameter int ADDR_BITS = rbaw_pkg::DEFAULT_ADDR_BITS,
  parameter int MAX_DIM   = rbaw_pkg::DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // src_pixel, dst_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // write_address, write_value, read_address
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rbaw_pkg::*;

  cfg_t        cfg_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        push, q_full, q_valid, pop;
  qent_t       push_data, q_data;
  front_stat_t fstat;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_start    <= '0;
      cfg_r.src_row_skip <= '0;
      cfg_r.dst_start    <= '0;
      cfg_r.dst_row_skip <= '0;
      cfg_r.rect_width   <= DimRegW'(1);
      cfg_r.rect_height  <= DimRegW'(1);
      cfg_r.raster_op    <= ROP_COPY;
      cfg_r.backward     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_START:    cfg_r.src_start    <= cfg_pwdata[FieldAddrW-1:0];
        REG_SRC_ROW_SKIP: cfg_r.src_row_skip <= cfg_pwdata[SkipW-1:0];
        REG_DST_START:    cfg_r.dst_start    <= cfg_pwdata[FieldAddrW-1:0];
        REG_DST_ROW_SKIP: cfg_r.dst_row_skip <= cfg_pwdata[SkipW-1:0];
        REG_RECT_WIDTH:   cfg_r.rect_width   <= cfg_pwdata[DimRegW-1:0];
        REG_RECT_HEIGHT:  cfg_r.rect_height  <= cfg_pwdata[DimRegW-1:0];
        REG_RASTER_OP:    cfg_r.raster_op    <= cfg_pwdata[RopW-1:0];
        REG_BACKWARD:     cfg_r.backward     <= cfg_pwdata[0];
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (cfg_idx)
      REG_SRC_START:    cfg_prdata = 32'(cfg_r.src_start);
      REG_SRC_ROW_SKIP: cfg_prdata = 32'(cfg_r.src_row_skip);
      REG_DST_START:    cfg_prdata = 32'(cfg_r.dst_start);
      REG_DST_ROW_SKIP: cfg_prdata = 32'(cfg_r.dst_row_skip);
      REG_RECT_WIDTH:   cfg_prdata = 32'(cfg_r.rect_width);
      REG_RECT_HEIGHT:  cfg_prdata = 32'(cfg_r.rect_height);
      REG_RASTER_OP:    cfg_prdata = 32'(cfg_r.raster_op);
      REG_BACKWARD:     cfg_prdata = 32'(cfg_r.backward);
    endcase
  end

  rbaw_front #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full),
    .stat      (fstat)
  );

  rbaw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rbaw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks
  `AST_NEXT(a_last_restarts, clk, rst_n, push && push_data.last, fstat.at_start, "no restart")
  `AST_NEXT(a_back_fills, clk, rst_n, q_valid && !out_tvalid, out_tvalid, "output not loaded")
  `AST_IMPL(a_pop_valid, clk, rst_n, pop, q_valid, "pop from empty queue")

endmodule

>>> hdl/rbaw_front.sv
module rbaw_front #(
  parameter int ADDR_BITS = rbaw_pkg::DEFAULT_ADDR_BITS,
  parameter int MAX_DIM   = rbaw_pkg::DEFAULT_MAX_DIM
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbaw_pkg::cfg_t            cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // src_pixel, dst_pixel
  output logic                      push,
  output rbaw_pkg::qent_t           push_data,
  input  logic                      q_full,
  output rbaw_pkg::front_stat_t     stat
);
  import rbaw_pkg::*;

  localparam int CntW = $clog2(MAX_DIM);
  localparam int DimW = (CntW + 1 > DimRegW) ? CntW + 1 : DimRegW;

  logic [CntW-1:0]      col_r, col_nxt;
  logic [CntW-1:0]      row_r, row_nxt;
  logic [ADDR_BITS-1:0] src_ptr_r, src_ptr_nxt;
  logic [ADDR_BITS-1:0] dst_ptr_r, dst_ptr_nxt;

  logic                 start;
  logic [ADDR_BITS-1:0] src_base, dst_base;
  logic [ADDR_BITS-1:0] src_cur, dst_cur;
  logic [ADDR_BITS-1:0] src_post, dst_post;
  logic [DimW-1:0]      eff_w, eff_h, dim_max;
  logic [DimW-1:0]      col_inc, row_inc;
  logic                 row_end, last;
  logic [AddrMaxW-1:0]  raddr_wide, waddr_wide;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign start     = (col_r == '0) && (row_r == '0);
  assign stat.at_start = start;

  // Clamp the configured sizes to 1..MAX_DIM
  assign dim_max = DimW'(MAX_DIM);
  always_comb begin
    eff_w = DimW'(cfg.rect_width);
    eff_h = DimW'(cfg.rect_height);
    if (eff_w == '0) eff_w = DimW'(1);
    else if (eff_w > dim_max) eff_w = dim_max;
    if (eff_h == '0) eff_h = DimW'(1);
    else if (eff_h > dim_max) eff_h = dim_max;
  end

  // Pointer walk: reload at rectangle start, then pre-dec or post-inc
  always_comb begin
    src_base = start ? ADDR_BITS'(AddrMaxW'(cfg.src_start)) : src_ptr_r;
    dst_base = start ? ADDR_BITS'(AddrMaxW'(cfg.dst_start)) : dst_ptr_r;
    if (cfg.backward) begin
      src_cur  = src_base - ADDR_BITS'(1);
      dst_cur  = dst_base - ADDR_BITS'(1);
      src_post = src_cur;
      dst_post = dst_cur;
    end else begin
      src_cur  = src_base;
      dst_cur  = dst_base;
      src_post = src_base + ADDR_BITS'(1);
      dst_post = dst_base + ADDR_BITS'(1);
    end
  end

  // Row and rectangle end
  assign col_inc = DimW'(col_r) + DimW'(1);
  assign row_inc = DimW'(row_r) + DimW'(1);
  assign row_end = col_inc >= eff_w;
  assign last    = row_end && (row_inc >= eff_h);

  always_comb begin
    src_ptr_nxt = src_post;
    dst_ptr_nxt = dst_post;
    col_nxt     = col_inc[CntW-1:0];
    row_nxt     = row_r;
    if (row_end) begin
      src_ptr_nxt = src_post + ADDR_BITS'($signed(cfg.src_row_skip));
      dst_ptr_nxt = dst_post + ADDR_BITS'($signed(cfg.dst_row_skip));
      col_nxt     = '0;
      row_nxt     = last ? '0 : row_inc[CntW-1:0];
    end
  end

  // Entry for the queue
  assign raddr_wide = AddrMaxW'(src_cur);
  assign waddr_wide = AddrMaxW'(dst_cur);
  always_comb begin
    push_data.waddr = waddr_wide[FieldAddrW-1:0];
    push_data.raddr = raddr_wide[FieldAddrW-1:0];
    push_data.src   = in_tdata[PixW-1:0];
    push_data.dst   = in_tdata[2*PixW-1:PixW];
    push_data.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      src_ptr_r <= '0;
      dst_ptr_r <= '0;
    end else if (push) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      src_ptr_r <= src_ptr_nxt;
      dst_ptr_r <= dst_ptr_nxt;
    end
  end

endmodule

>>> hdl/rbaw_fifo.sv
module rbaw_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rbaw_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output rbaw_pkg::qent_t q_data
);
  import rbaw_pkg::*;

  qent_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> hdl/rbaw_back.sv
module rbaw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rbaw_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  rbaw_pkg::qent_t q_data,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,  // write_address, write_value, read_address
  output logic            out_tlast   // last_pixel
);
  import rbaw_pkg::*;

  logic                  out_valid_r;
  logic [FieldAddrW-1:0] waddr_r, raddr_r;
  logic [PixW-1:0]       wval_r;
  logic                  last_r;

  // Load the output register whenever it is free or being drained
  assign pop = q_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      waddr_r <= q_data.waddr;
      raddr_r <= q_data.raddr;
      wval_r  <= rop_combine(cfg.raster_op, q_data.src, q_data.dst);
      last_r  <= q_data.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {raddr_r, wval_r, waddr_r};
  assign out_tlast  = last_r;

endmodule

>>> tb/rop_blit_address_walker_unit_tb.sv
module rop_blit_address_walker_unit_tb;
  import rbaw_pkg::*;

  localparam int QUIET_LIMIT   = 200;   // cycles with no handshake before giving up
  localparam int RANDOM_PIXELS = 960;
  localparam int CLAMP_RUN     = 40;    // words sent into an oversize row
  localparam int DIM_CAP       = DEFAULT_MAX_DIM;
  localparam int DIM_REG_MAX   = (1 << DimRegW) - 1;

  // One destination write as seen on the out_ channel
  typedef struct packed {
    logic [FieldAddrW-1:0] write_address;
    logic [PixW-1:0]       write_value;
    logic [FieldAddrW-1:0] read_address;
    logic                  last_pixel;
  } blit_write_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // src_pixel[15:0], dst_pixel[31:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // write_address[23:0], write_value[39:24], read_address[63:40]
  logic        out_tlast;   // last_pixel
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Register shadows
  logic [FieldAddrW-1:0] sh_src_start;
  logic [FieldAddrW-1:0] sh_dst_start;
  logic [SkipW-1:0]      sh_src_skip;
  logic [SkipW-1:0]      sh_dst_skip;
  logic [DimRegW-1:0]    sh_width;
  logic [DimRegW-1:0]    sh_height;
  rop_t                  sh_rop;
  logic                  sh_backward;

  // Walker state
  int unsigned           col_count;
  int unsigned           row_count;
  logic [FieldAddrW-1:0] src_ptr;
  logic [FieldAddrW-1:0] dst_ptr;

  blit_write_t pixel_writes_due[$];

  bit in_burst;
  bit out_burst;
  int mismatch_count;
  int pixels_sent;
  int writes_checked;
  int rects_closed;
  int quiet_cycles;

  rop_blit_address_walker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle cycles before the next word on either side
  function automatic int wait_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  // Zero acts as one, anything past the cap acts as the cap
  function automatic int unsigned eff_dim(input logic [DimRegW-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return 32'(v);
  endfunction

  // Raster op as a truth table: bit 0 picks s&d, 1 s&~d, 2 ~s&d, 3 ~s&~d
  function automatic logic [PixW-1:0] rop_value(input rop_t op, input logic [PixW-1:0] s,
                                                input logic [PixW-1:0] d);
    return ({PixW{op[0]}} &  s &  d) | ({PixW{op[1]}} &  s & ~d) |
           ({PixW{op[2]}} & ~s &  d) | ({PixW{op[3]}} & ~s & ~d);
  endfunction

  // Advance the walker by one pixel pair and queue the write it produces
  function automatic void walk_pixel(input logic [PixW-1:0] s, input logic [PixW-1:0] d);
    int unsigned w;
    int unsigned h;
    bit          row_end;
    blit_write_t wr;
    w = eff_dim(sh_width);
    h = eff_dim(sh_height);
    if (col_count == 0 && row_count == 0) begin
      src_ptr = sh_src_start;
      dst_ptr = sh_dst_start;
    end
    if (sh_backward) begin
      src_ptr = src_ptr - FieldAddrW'(1);
      dst_ptr = dst_ptr - FieldAddrW'(1);
      wr.read_address  = src_ptr;
      wr.write_address = dst_ptr;
    end else begin
      wr.read_address  = src_ptr;
      wr.write_address = dst_ptr;
      src_ptr = src_ptr + FieldAddrW'(1);
      dst_ptr = dst_ptr + FieldAddrW'(1);
    end
    row_end = (col_count + 1) >= w;
    wr.last_pixel = row_end && ((row_count + 1) >= h);
    wr.write_value = rop_value(sh_rop, s, d);
    if (row_end) begin
      // line adds are sign extended to the pointer width
      src_ptr = src_ptr + {{(FieldAddrW-SkipW){sh_src_skip[SkipW-1]}}, sh_src_skip};
      dst_ptr = dst_ptr + {{(FieldAddrW-SkipW){sh_dst_skip[SkipW-1]}}, sh_dst_skip};
      col_count = 0;
      row_count = wr.last_pixel ? 0 : row_count + 1;
    end else begin
      col_count++;
    end
    pixel_writes_due.push_back(wr);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [31:0] pick_address();
    logic [FieldAddrW-1:0] a;
    case ($urandom_range(0, 3))
      0:       a = FieldAddrW'($urandom_range(0, 15));
      1:       a = {FieldAddrW{1'b1}} - FieldAddrW'($urandom_range(0, 15));
      default: a = FieldAddrW'($urandom());
    endcase
    return {8'($urandom()), a};
  endfunction

  function automatic logic [31:0] pick_skip();
    logic [SkipW-1:0] k;
    case ($urandom_range(0, 5))
      0:       k = 16'h8000;
      1:       k = 16'h7fff;
      2, 3:    k = 16'($urandom_range(0, 32)) - 16'd16;
      default: k = SkipW'($urandom());
    endcase
    return {16'($urandom()), k};
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom());
    endcase
  endfunction

  // APB write: setup, access, then psel drops back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (cfg_pready !== 1'b1);
    @(posedge clk);
    case (idx)
      REG_SRC_START:    sh_src_start = value[FieldAddrW-1:0];
      REG_SRC_ROW_SKIP: sh_src_skip  = value[SkipW-1:0];
      REG_DST_START:    sh_dst_start = value[FieldAddrW-1:0];
      REG_DST_ROW_SKIP: sh_dst_skip  = value[SkipW-1:0];
      REG_RECT_WIDTH:   sh_width     = value[DimRegW-1:0];
      REG_RECT_HEIGHT:  sh_height    = value[DimRegW-1:0];
      REG_RASTER_OP:    sh_rop       = rop_t'(value[RopW-1:0]);
      REG_BACKWARD:     sh_backward  = value[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Send one pixel pair; valid stays up after the handshake
  task automatic send_pixel(input logic [PixW-1:0] s, input logic [PixW-1:0] d);
    int gap;
    gap = wait_cycles(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, s};
    do @(negedge clk); while (in_tready !== 1'b1);
    @(posedge clk);
    walk_pixel(s, d);
    pixels_sent++;
  endtask

  // Stop sending and wait for every queued write to come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_writes_due.size() != 0) @(posedge clk);
  endtask

  // Reset values: 1x1 copy rectangle at address zero
  task automatic test_reset_defaults();
    send_pixel(16'hffff, 16'h0000);
  endtask

  // All 16 ops, one word each, with every s/d bit pairing in the word
  task automatic test_raster_ops();
    rop_t op;
    wait_drained();
    write_reg(REG_SRC_START, 32'h0012_3456);
    write_reg(REG_DST_START, 32'h0080_0000);
    write_reg(REG_SRC_ROW_SKIP, 32'd3);
    write_reg(REG_DST_ROW_SKIP, 32'h0000_fffb);
    write_reg(REG_RECT_WIDTH, 32'd4);
    write_reg(REG_RECT_HEIGHT, 32'd2);
    op = op.first();
    do begin
      wait_drained();
      write_reg(REG_RASTER_OP, 32'(op));
      send_pixel(16'h00ff, 16'h0f0f);
      op = op.next();
    end while (op != op.first());
  endtask

  // Zero width and height act as one: every word closes a rectangle
  task automatic test_zero_size();
    wait_drained();
    write_reg(REG_RASTER_OP, 32'(ROP_OR));
    write_reg(REG_RECT_WIDTH, 32'd0);
    write_reg(REG_RECT_HEIGHT, 32'd0);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hffff, 16'h0000);
  endtask

  // Pre-decrement below zero, extreme line adds, then forward past the top
  task automatic test_pointer_wrap();
    wait_drained();
    write_reg(REG_SRC_START, 32'h0000_0000);
    write_reg(REG_DST_START, 32'h00ff_ffff);
    write_reg(REG_SRC_ROW_SKIP, 32'h0000_8000);
    write_reg(REG_DST_ROW_SKIP, 32'h0000_7fff);
    write_reg(REG_RECT_WIDTH, 32'd2);
    write_reg(REG_RECT_HEIGHT, 32'd2);
    write_reg(REG_RASTER_OP, 32'(ROP_XOR));
    write_reg(REG_BACKWARD, 32'd1);
    send_pixel(16'h0000, 16'hffff);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'hffff, 16'hffff);
    wait_drained();
    write_reg(REG_BACKWARD, 32'd0);
    write_reg(REG_SRC_START, 32'h00ff_ffff);
    write_reg(REG_DST_START, 32'h0000_0000);
    send_pixel(16'h1234, 16'h8001);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'h0000, 16'hffff);
  endtask

  // Shrink the rectangle under a running row: the row and the rectangle close at once
  task automatic test_mid_rect_resize();
    wait_drained();
    write_reg(REG_RECT_WIDTH, 32'd6);
    write_reg(REG_RECT_HEIGHT, 32'd3);
    write_reg(REG_RASTER_OP, 32'(ROP_COPY));
    send_pixel(16'h0001, 16'h8000);
    send_pixel(16'h8000, 16'h0001);
    wait_drained();
    write_reg(REG_RECT_WIDTH, 32'd2);
    write_reg(REG_RECT_HEIGHT, 32'd1);
    send_pixel(16'h5555, 16'haaaa);
    send_pixel(16'haaaa, 16'h5555);
  endtask

  // Oversize width: a long burst that must not close the row, then an oversize height
  task automatic test_size_clamp();
    wait_drained();
    in_burst  = 1'b1;
    out_burst = 1'b1;
    write_reg(REG_SRC_ROW_SKIP, 32'd100);
    write_reg(REG_DST_ROW_SKIP, 32'h0000_ff9c);
    write_reg(REG_RECT_WIDTH, DIM_REG_MAX);
    write_reg(REG_RECT_HEIGHT, DIM_REG_MAX);
    repeat (CLAMP_RUN) send_pixel(pick_pixel(), pick_pixel());
    wait_drained();
    in_burst  = 1'b0;
    out_burst = 1'b0;
    // one column, one row: the next word closes the open rectangle
    write_reg(REG_RECT_WIDTH, 32'd1);
    write_reg(REG_RECT_HEIGHT, 32'd1);
    send_pixel(pick_pixel(), pick_pixel());
    wait_drained();
    write_reg(REG_RECT_HEIGHT, DIM_CAP + 1);
    repeat (3) send_pixel(pick_pixel(), pick_pixel());
    wait_drained();
    write_reg(REG_RECT_HEIGHT, 32'd2);
    repeat (2) send_pixel(pick_pixel(), pick_pixel());
  endtask

  // Random setups between drains; small rectangles, some partial, a few oversize
  task automatic test_random_rects();
    int unsigned pixels_done;
    int unsigned w;
    int unsigned h;
    int unsigned area;
    int unsigned n;
    pixels_done = 0;
    while (pixels_done < RANDOM_PIXELS) begin
      wait_drained();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:       w = 0;
        1:       w = $urandom_range(DIM_CAP + 1, DIM_REG_MAX);
        2:       w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_START, pick_address());
      if ($urandom_range(0, 3) != 0) write_reg(REG_DST_START, pick_address());
      if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_ROW_SKIP, pick_skip());
      if ($urandom_range(0, 3) != 0) write_reg(REG_DST_ROW_SKIP, pick_skip());
      if ($urandom_range(0, 4) != 0)
        write_reg(REG_RECT_WIDTH, ($urandom() & ~32'h1fff) | w);
      if ($urandom_range(0, 4) != 0)
        write_reg(REG_RECT_HEIGHT, ($urandom() & ~32'h1fff) | h);
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_RASTER_OP, ($urandom() & ~32'hf) | 32'(rop_t'(4'($urandom_range(0, 15)))));
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_BACKWARD, $urandom());
      // word count: whole rectangles mostly, partials now and then
      area = (w > 64 ? 20 : (w == 0 ? 1 : w)) * (h == 0 ? 1 : h);
      n = $urandom_range(1, 2 * area);
      if (n > 120) n = 120;
      repeat (n) send_pixel(pick_pixel(), pick_pixel());
      pixels_done += n;
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  // Write-side checker: random stalls on out_tready, compare against the oldest due write
  initial begin : write_checker
    blit_write_t due;
    logic [63:0] word;
    logic        lastbit;
    int          gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = wait_cycles(out_burst);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (out_tvalid !== 1'b1);
      word    = out_tdata;
      lastbit = out_tlast;
      @(posedge clk);
      if (pixel_writes_due.size() == 0) begin
        $error("write word %h with nothing pending", word);
        mismatch_count++;
      end else begin
        due = pixel_writes_due.pop_front();
        check_field("write_address", 32'(due.write_address), 32'(word[23:0]));
        check_field("write_value", 32'(due.write_value), 32'(word[39:24]));
        check_field("read_address", 32'(due.read_address), 32'(word[63:40]));
        check_field("last_pixel", 32'(due.last_pixel), 32'(lastbit));
        writes_checked++;
        if (lastbit) rects_closed++;
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[rop_blit_address_walker_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    sh_src_start = '0;
    sh_dst_start = '0;
    sh_src_skip  = '0;
    sh_dst_skip  = '0;
    sh_width     = DimRegW'(1);
    sh_height    = DimRegW'(1);
    sh_rop       = ROP_COPY;
    sh_backward  = 1'b0;
    col_count    = 0;
    row_count    = 0;
    src_ptr      = '0;
    dst_ptr      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_raster_ops();
    test_zero_size();
    test_pointer_wrap();
    test_mid_rect_resize();
    test_size_clamp();
    test_random_rects();

    wait_drained();
    repeat (8) @(posedge clk);
    if (pixel_writes_due.size() != 0) begin
      $error("%0d writes never arrived", pixel_writes_due.size());
      mismatch_count++;
    end
    $display("Ran %0d pixel pairs, checked %0d writes, closed %0d rectangles",
             pixels_sent, writes_checked, rects_closed);
    $display("Walked all 16 raster ops, both directions, pointer wrap, zero and oversize sizes");
    if (mismatch_count == 0) begin
      $display("[rop_blit_address_walker_unit] OK");
    end else begin
      $display("[rop_blit_address_walker_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/rbaw_pkg.sv
hdl/rbaw_front.sv
hdl/rbaw_fifo.sv
hdl/rbaw_back.sv
hdl/rop_blit_address_walker_unit.sv
tb/rop_blit_address_walker_unit_tb.sv
